/* hdl/hjg_pkg.sv */
package hjg_pkg;

    // fixed point and field widths
    localparam int FRAC_BITS = 24;
    localparam int BASE_X    = 2;
    localparam int BASE_Y    = 3;
    localparam int FRAME_W   = 31;
    localparam int OFS_W     = 24;
    localparam int BASE_W    = 5;
    localparam int NLANE     = 2;
    localparam int IN_W      = 32;
    localparam int OUT_W     = 4 * OFS_W;

    // digit reversal accumulator: b^m <= n * b < 2^(FRAME_W + BASE_W - 1)
    localparam int ACC_W  = FRAME_W + BASE_W - 1;
    localparam int CNT_W  = $clog2(FRAC_BITS + 1);

    // bases below two count as two
    localparam int BX = (BASE_X < 2) ? 2 : BASE_X;
    localparam int BY = (BASE_Y < 2) ? 2 : BASE_Y;

    // reciprocal for exact n / b with n < 2^FRAME_W
    localparam int RECIP_W = FRAME_W + 2;
    localparam int PROD_W  = FRAME_W + RECIP_W;
    localparam int SHIFT_X = FRAME_W + $clog2(BX);
    localparam int SHIFT_Y = FRAME_W + $clog2(BY);
    localparam logic [RECIP_W-1:0] RECIP_X =
        RECIP_W'(((64'd1 << SHIFT_X) + 64'(BX) - 64'd1) / 64'(BX));
    localparam logic [RECIP_W-1:0] RECIP_Y =
        RECIP_W'(((64'd1 << SHIFT_Y) + 64'(BY) - 64'd1) / 64'(BY));

    // saturation of the centered quotient to the output range
    localparam int SAT_W = ((FRAC_BITS > OFS_W) ? FRAC_BITS : OFS_W) + 2;
    localparam logic signed [SAT_W-1:0] OFS_MAX = SAT_W'((64'd1 << (OFS_W - 1)) - 64'd1);
    localparam logic signed [SAT_W-1:0] OFS_MIN = -OFS_MAX - SAT_W'(1);

    typedef struct packed {
        logic load;         // start a radical inverse on the frame number
        logic step_digit;   // peel one digit in each lane
        logic step_div;     // one quotient bit in each lane
        logic commit;       // old <= cur, cur <= new offsets
        logic commit_zero;  // old <= cur, cur <= zero
        logic out_load;     // capture the result beat
    } hjg_cmd_t;

    typedef struct packed {
        logic digits_done;  // every lane has run out of digits
    } hjg_status_t;

    function automatic logic [BASE_W-1:0] lane_base(input logic lane);
        lane_base = lane ? BASE_W'(BY) : BASE_W'(BX);
    endfunction

    function automatic logic [RECIP_W-1:0] lane_recip(input logic lane);
        lane_recip = lane ? RECIP_Y : RECIP_X;
    endfunction

    function automatic int lane_shift(input logic lane);
        lane_shift = lane ? SHIFT_Y : SHIFT_X;
    endfunction

    function automatic logic signed [OFS_W-1:0] sat_offset(input logic [FRAC_BITS-1:0] q);
        logic signed [SAT_W-1:0] v;
        v = $signed(SAT_W'(q)) - $signed(SAT_W'(1) << (FRAC_BITS - 1));
        if (v > OFS_MAX) begin
            v = OFS_MAX;
        end else if (v < OFS_MIN) begin
            v = OFS_MIN;
        end
        sat_offset = v[OFS_W-1:0];
    endfunction

endpackage

/* hdl/hjg_datapath.sv */
module hjg_datapath (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [hjg_pkg::FRAME_W-1:0] frame_number,
    input  hjg_pkg::hjg_cmd_t           cmd,
    output hjg_pkg::hjg_status_t        status,
    output logic [hjg_pkg::OUT_W-1:0]   out_data
);
    import hjg_pkg::*;

    logic [FRAME_W-1:0]          n_reg   [NLANE];
    logic [FRAME_W-1:0]          n_next  [NLANE];
    logic [ACC_W-1:0]            acc_reg [NLANE];
    logic [ACC_W-1:0]            acc_next[NLANE];
    logic [ACC_W-1:0]            den_reg [NLANE];
    logic [ACC_W-1:0]            den_next[NLANE];
    logic [FRAC_BITS-1:0]        q_reg   [NLANE];
    logic [FRAC_BITS-1:0]        q_next  [NLANE];
    logic signed [OFS_W-1:0]     cur_reg [NLANE];
    logic signed [OFS_W-1:0]     cur_next[NLANE];
    logic signed [OFS_W-1:0]     old_reg [NLANE];
    logic signed [OFS_W-1:0]     old_next[NLANE];
    logic [OUT_W-1:0]            out_reg;
    logic [OUT_W-1:0]            out_next;

    logic [PROD_W-1:0]           prod    [NLANE];
    logic [FRAME_W-1:0]          quo     [NLANE];
    logic [BASE_W-1:0]           dig     [NLANE];
    logic [ACC_W:0]              shifted [NLANE];
    logic                        ge      [NLANE];

    always_comb begin
        for (int l = 0; l < NLANE; l++) begin
            // digit step: n = q * b + d, rev = rev * b + d
            prod[l]    = PROD_W'(n_reg[l]) * PROD_W'(lane_recip(l == 1));
            quo[l]     = FRAME_W'(prod[l] >> lane_shift(l == 1));
            dig[l]     = BASE_W'(n_reg[l] - FRAME_W'(quo[l] * FRAME_W'(lane_base(l == 1))));
            // restoring division step
            shifted[l] = {acc_reg[l], 1'b0};
            ge[l]      = shifted[l] >= {1'b0, den_reg[l]};

            n_next[l]   = n_reg[l];
            acc_next[l] = acc_reg[l];
            den_next[l] = den_reg[l];
            q_next[l]   = q_reg[l];
            cur_next[l] = cur_reg[l];
            old_next[l] = old_reg[l];

            if (cmd.load) begin
                n_next[l]   = frame_number;
                acc_next[l] = '0;
                den_next[l] = ACC_W'(1);
                q_next[l]   = '0;
            end else if (cmd.step_digit) begin
                if (n_reg[l] != '0) begin
                    n_next[l]   = quo[l];
                    acc_next[l] = ACC_W'(acc_reg[l] * ACC_W'(lane_base(l == 1)))
                                  + ACC_W'(dig[l]);
                    den_next[l] = ACC_W'(den_reg[l] * ACC_W'(lane_base(l == 1)));
                end
            end else if (cmd.step_div) begin
                acc_next[l] = ge[l] ? ACC_W'(shifted[l] - {1'b0, den_reg[l]})
                                    : ACC_W'(shifted[l]);
                q_next[l]   = {q_reg[l][FRAC_BITS-2:0], ge[l]};
            end

            if (cmd.commit) begin
                old_next[l] = cur_reg[l];
                cur_next[l] = sat_offset(q_reg[l]);
            end else if (cmd.commit_zero) begin
                old_next[l] = cur_reg[l];
                cur_next[l] = '0;
            end
        end

        out_next = out_reg;
        if (cmd.out_load) begin
            out_next = {old_reg[1], old_reg[0], cur_reg[1], cur_reg[0]};
        end
    end

    always_ff @(posedge aclk) begin
        for (int l = 0; l < NLANE; l++) begin
            n_reg[l]   <= n_next[l];
            acc_reg[l] <= acc_next[l];
            den_reg[l] <= den_next[l];
            q_reg[l]   <= q_next[l];
        end
        out_reg <= out_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int l = 0; l < NLANE; l++) begin
                cur_reg[l] <= '0;
                old_reg[l] <= '0;
            end
        end else begin
            for (int l = 0; l < NLANE; l++) begin
                cur_reg[l] <= cur_next[l];
                old_reg[l] <= old_next[l];
            end
        end
    end

    assign status.digits_done = (n_reg[0] == '0) && (n_reg[1] == '0);
    assign out_data           = out_reg;

endmodule

/* hdl/hjg_ctrl.sv */
module hjg_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic                  s_advance,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic                  cfg_wr_en,
    input  logic                  cfg_wr_data,
    input  hjg_pkg::hjg_status_t  status,
    output hjg_pkg::hjg_cmd_t     cmd
);
    import hjg_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_DIGIT  = 5'b00010,
        ST_DIV    = 5'b00100,
        ST_COMMIT = 5'b01000,
        ST_DONE   = 5'b10000
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic               disable_reg, disable_next;
    logic               accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        disable_next  = cfg_wr_en ? cfg_wr_data : disable_reg;
        cmd           = '0;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_advance && !disable_reg) begin
                        cmd.load   = 1'b1;
                        state_next = ST_DIGIT;
                    end else begin
                        cmd.commit_zero = s_advance;
                        state_next      = ST_DONE;
                    end
                end
            end
            ST_DIGIT: begin
                if (status.digits_done) begin
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end else begin
                    cmd.step_digit = 1'b1;
                end
            end
            ST_DIV: begin
                cmd.step_div = 1'b1;
                cnt_next     = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(FRAC_BITS - 1)) begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                cmd.commit = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (cmd.out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
            disable_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
            disable_reg  <= disable_next;
        end
    end

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (cnt_reg < CNT_W'(FRAC_BITS)))
        else $error("division count overran");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_tvalid_reg || m_tready))
        else $error("pending result beat overwritten");

    a_start_digits: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_advance && !disable_reg) |=> (state_reg == ST_DIGIT))
        else $error("advancing beat did not start digit reversal");

    a_div_after_digits: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> status.digits_done)
        else $error("division started with digits left");
`endif

endmodule

/* hdl/halton_jitter_generator_core.sv */
// Halton sub-pixel jitter, bases 2 (x) and 3 (y). Each input beat carries a frame
// number and a time-advanced flag and yields exactly one result beat holding the
// current and the previous offset pair, 24-bit two's complement scaled by 2^-24.
// With time advanced the current pair moves to the previous pair and the new
// current pair is the exactly truncated radical inverse minus one half (zero when
// disable_jitter is set); otherwise the pair is returned unchanged. A jittered beat
// runs the digit loop over the larger digit count of the frame number over the two
// bases (up to 31 in base 2), peeling one digit per lane per cycle, then the
// restoring division, one quotient bit per lane per cycle. One beat is in work at a
// time; a finished result sits in an output register while the next beat is accepted.
// The user must write disable_jitter only while the block is idle; the block itself
// does not enforce this.
module halton_jitter_generator_core (
    input  logic                      aclk,
    input  logic                      aresetn,
    // input stream
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [hjg_pkg::IN_W-1:0]  s_tdata,   // frame_number[30:0], time_advanced[31]
    // result stream
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [hjg_pkg::OUT_W-1:0] m_tdata,   // jitter_x[23:0], jitter_y[47:24],
                                                 // prev_jitter_x[71:48], prev_jitter_y[95:72]
    // configuration: disable_jitter
    input  logic                      cfg_wr_en,
    input  logic                      cfg_wr_data
);
    import hjg_pkg::*;

    hjg_cmd_t    cmd;
    hjg_status_t status;

    // sequencer: accept, digit loop, division loop, commit, result beat
    hjg_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_advance   (s_tdata[FRAME_W]),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .status      (status),
        .cmd         (cmd)
    );

    // two radical-inverse lanes, offset state and the output register
    hjg_datapath u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .frame_number (s_tdata[FRAME_W-1:0]),
        .cmd          (cmd),
        .status       (status),
        .out_data     (m_tdata)
    );

endmodule
